// ===== hdl/dde_pkg.sv =====
// shared types and constants for the digram dictionary encoder
// no dependencies
`timescale 1ns / 1ps

package dde_pkg;

  localparam int DICT_SIZE = 128;
  localparam int IDX_W     = $clog2(DICT_SIZE);
  localparam int CNT_W     = $clog2(DICT_SIZE + 1);

  localparam logic [7:0] CODE_BASE = 8'd128;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_EOS  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } pair_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_code;
    logic       last;
  } res_t;

endpackage

// ===== hdl/digram_dictionary_encoder.sv =====
// top level of the digram dictionary encoder: config register, output register
// depends on dde_pkg, dde_dict, dde_ctrl
`timescale 1ns / 1ps

// Greedy digram encoder. Load items (func 0) write a byte pair into one of 128
// dictionary slots. A data item (func 1) that arrives with no byte held only
// holds it; otherwise the pair of held byte and new byte is compared against
// slots 0 .. min(dict_entries,128)-1, lowest first, and either the code
// 128+index or the held byte as a literal comes out. The search runs through
// the single read port of the dictionary store feeding one pair comparator,
// one slot a cycle, stops at the first match, and then hands the result over.
// End of stream (func 2) flushes a held byte marked last. in_stall is high
// while an item is being worked on. Results leave through an output register,
// so a stalled result does not block new items until the next result is ready.
// cfg_data sets dict_entries; the user must write it only while the block is
// idle, and the block itself does not enforce it.
module digram_dictionary_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [6:0] in_entry_index,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_code,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import dde_pkg::*;

  logic [7:0]       dict_entries_r;
  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             busy;
  logic             wr_en;
  logic             out_free;
  logic [IDX_W-1:0] rd_addr;
  pair_t            wr_data;
  pair_t            rd_data;
  res_t             res;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_is_code_r;
  logic       out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_entries_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dict_entries_r <= cfg_data;
    end
  end

  // counts above the store depth search the whole store
  assign limit = (dict_entries_r > 8'(DICT_SIZE)) ? CNT_W'(DICT_SIZE)
                                                  : CNT_W'(dict_entries_r);

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (func_t'(in_func) == FUNC_LOAD)
                    && ({1'b0, in_entry_index} < 8'(DICT_SIZE));
  assign wr_data.first  = in_first_byte;
  assign wr_data.second = in_second_byte;

  dde_dict u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;

  dde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .data_byte (in_data_byte),
    .limit     (limit),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .rd_addr   (rd_addr),
    .busy      (busy),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
    if (out_free && res.valid) begin
      out_byte_r    <= res.out_byte;
      out_is_code_r <= res.is_code;
      out_last_r    <= res.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_code = out_is_code_r;
  assign out_last    = out_last_r;

endmodule

// ===== hdl/dde_dict.sv =====
// dictionary store: one write port, one registered read port
// depends on dde_pkg
`timescale 1ns / 1ps

module dde_dict (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [dde_pkg::IDX_W-1:0] wr_addr,
  input  dde_pkg::pair_t           wr_data,
  input  logic [dde_pkg::IDX_W-1:0] rd_addr,
  output dde_pkg::pair_t           rd_data
);
  import dde_pkg::*;

  pair_t mem [DICT_SIZE];
  pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/dde_ctrl.sv =====
// sequencer: holds the pending byte and scans the dictionary one entry a cycle
// through a single pair comparator; depends on dde_pkg
`timescale 1ns / 1ps

module dde_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 func,
  input  logic [7:0]                 data_byte,
  input  logic [dde_pkg::CNT_W-1:0]  limit,
  input  dde_pkg::pair_t             rd_data,
  input  logic                       out_free,
  output logic [dde_pkg::IDX_W-1:0]  rd_addr,
  output logic                       busy,
  output dde_pkg::res_t              res
);
  import dde_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        held_byte_r, held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [7:0]        cur_byte_r, cur_byte_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  res_t              res_r, res_nxt;

  logic issue;
  logic match;

  assign issue   = (cnt_r < limit);
  assign match   = cmp_valid_r && (rd_data.first == held_byte_r)
                   && (rd_data.second == cur_byte_r);
  assign rd_addr = cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    cur_byte_nxt   = cur_byte_r;
    cnt_nxt        = cnt_r;
    cmp_valid_nxt  = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    res_nxt        = res_r;
    case (state_r)
      ST_IDLE: begin
        res_nxt.valid = 1'b0;
        if (accept) begin
          case (func_t'(func))
            FUNC_DATA: begin
              if (!held_valid_r) begin
                held_byte_nxt  = data_byte;
                held_valid_nxt = 1'b1;
              end else begin
                cur_byte_nxt = data_byte;
                cnt_nxt      = '0;
                state_nxt    = ST_SCAN;
              end
            end
            FUNC_EOS: begin
              if (held_valid_r) begin
                res_nxt.valid    = 1'b1;
                res_nxt.out_byte = held_byte_r;
                res_nxt.is_code  = 1'b0;
                res_nxt.last     = 1'b1;
                held_valid_nxt   = 1'b0;
                held_byte_nxt    = '0;
                state_nxt        = ST_DONE;
              end
            end
            default: begin
              // loads are written straight into the store, func 3 is dropped
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read of entry cnt overlaps the compare of entry cnt-1
        cmp_valid_nxt = issue;
        cmp_idx_nxt   = cnt_r[IDX_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (match) begin
          res_nxt.valid    = 1'b1;
          res_nxt.out_byte = CODE_BASE + {{(8-IDX_W){1'b0}}, cmp_idx_r};
          res_nxt.is_code  = 1'b1;
          res_nxt.last     = 1'b0;
          held_valid_nxt   = 1'b0;
          held_byte_nxt    = '0;
          cmp_valid_nxt    = 1'b0;
          state_nxt        = ST_DONE;
        end else if (!issue) begin
          res_nxt.valid    = 1'b1;
          res_nxt.out_byte = held_byte_r;
          res_nxt.is_code  = 1'b0;
          res_nxt.last     = 1'b0;
          held_byte_nxt    = cur_byte_r;
          cmp_valid_nxt    = 1'b0;
          state_nxt        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_nxt.valid = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      cmp_valid_r  <= 1'b0;
      res_r.valid  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      res_r.valid  <= res_nxt.valid;
    end
    cur_byte_r       <= cur_byte_nxt;
    cnt_r            <= cnt_nxt;
    cmp_idx_r        <= cmp_idx_nxt;
    res_r.out_byte   <= res_nxt.out_byte;
    res_r.is_code    <= res_nxt.is_code;
    res_r.last       <= res_nxt.last;
  end

  assign busy = (state_r != ST_IDLE);
  // result is offered only while waiting in the done state
  always_comb begin
    res       = res_r;
    res.valid = res_r.valid && (state_r == ST_DONE);
  end

endmodule

// ===== verif/dde_tb_pkg.sv =====
// item and symbol types plus the scoreboard class for the digram encoder testbench
// depends on dde_pkg
`timescale 1ns / 1ps

package dde_tb_pkg;

  import dde_pkg::*;

  typedef struct packed {
    func_t      func;
    logic [6:0] entry_index;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] data_byte;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       is_code;
    logic       last;
  } enc_symbol_t;

  class dde_scoreboard;
    logic [7:0]  slot_first [DICT_SIZE];
    logic [7:0]  slot_second [DICT_SIZE];
    logic [7:0]  held_byte;
    bit          held_valid;
    logic [7:0]  dict_entries;
    enc_symbol_t symbols_due[$];
    int          errors;
    int          items_seen;
    int          symbols_seen;
    int          codes_seen;
    int          flushes_seen;

    function new();
      held_byte    = '0;
      held_valid   = 1'b0;
      dict_entries = '0;
      errors       = 0;
      items_seen   = 0;
      symbols_seen = 0;
      codes_seen   = 0;
      flushes_seen = 0;
    endfunction

    function void set_dict_entries(logic [7:0] count);
      dict_entries = count;
    endfunction

    // models each accepted item: loads, flushes and the greedy pair search, lowest slot wins
    function void note_accepted(enc_item_t it);
      enc_symbol_t s;
      int          span;
      int          i;
      bit          hit;
      items_seen++;
      case (it.func)
        FUNC_LOAD: begin
          slot_first[it.entry_index]  = it.first_byte;
          slot_second[it.entry_index] = it.second_byte;
        end
        FUNC_DATA: begin
          if (!held_valid) begin
            held_byte  = it.data_byte;
            held_valid = 1'b1;
          end else begin
            span = (dict_entries > DICT_SIZE) ? DICT_SIZE : dict_entries;
            hit  = 1'b0;
            for (i = 0; i < span && !hit; i++) begin
              if (slot_first[i[6:0]] == held_byte
                  && slot_second[i[6:0]] == it.data_byte) begin
                s.sym     = CODE_BASE + i[7:0];
                s.is_code = 1'b1;
                s.last    = 1'b0;
                hit       = 1'b1;
              end
            end
            if (hit) begin
              held_valid = 1'b0;
              held_byte  = '0;
            end else begin
              s.sym     = held_byte;
              s.is_code = 1'b0;
              s.last    = 1'b0;
              held_byte = it.data_byte;
            end
            symbols_due.push_back(s);
          end
        end
        FUNC_EOS: begin
          if (held_valid) begin
            s.sym     = held_byte;
            s.is_code = 1'b0;
            s.last    = 1'b1;
            symbols_due.push_back(s);
            held_valid = 1'b0;
            held_byte  = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_symbol(logic [7:0] sym, logic is_code, logic last);
      enc_symbol_t want;
      if (symbols_due.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %02h code %0b last %0b",
                                  sym, is_code, last));
        return;
      end
      want = symbols_due.pop_front();
      symbols_seen++;
      if (want.is_code) codes_seen++;
      if (want.last) flushes_seen++;
      if (sym !== want.sym)
        report_mismatch($sformatf("out_byte %02h, want %02h", sym, want.sym));
      if (is_code !== want.is_code)
        report_mismatch($sformatf("is_code %0b, want %0b", is_code, want.is_code));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

endpackage

// ===== verif/tb_top.sv =====
// top of the digram encoder testbench: clock, reset, stimulus, output side, end of run
// depends on dde_pkg, dde_tb_pkg and digram_dictionary_encoder
`timescale 1ns / 1ps

module tb_top;

  import dde_pkg::*;
  import dde_tb_pkg::*;

  // longest item (full search plus handover) with margin
  localparam int SETTLE_CYCLES = 2 * DICT_SIZE + 16;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 10;
  localparam int HOLD_CYCLES   = 900;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [6:0] in_entry_index;
  logic [7:0] in_first_byte;
  logic [7:0] in_second_byte;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_code;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  dde_scoreboard enc_sb;
  int            calm_in = 0;
  int            settings_used = 0;

  digram_dictionary_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_first_byte  (in_first_byte),
    .in_second_byte (in_second_byte),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_code    (out_is_code),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      enc_sb.check_symbol(out_byte, out_is_code, out_last);
  end

  function automatic enc_item_t make_item(func_t f);
    enc_item_t it;
    it.func        = f;
    it.entry_index = 7'($urandom);
    it.first_byte  = 8'($urandom);
    it.second_byte = 8'($urandom);
    it.data_byte   = 8'($urandom);
    return it;
  endfunction

  // mostly a small text alphabet so pairs repeat and hit the dictionary
  function automatic logic [7:0] pick_byte(int unsigned wide_pct);
    if ($urandom_range(0, 99) < wide_pct)
      return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 5));
  endfunction

  task automatic send_item(enc_item_t it);
    int r;
    int gap;
    gap = 0;
    if (calm_in > 0) begin
      calm_in--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) calm_in = $urandom_range(20, 60);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_entry_index <= it.entry_index;
    in_first_byte  <= it.first_byte;
    in_second_byte <= it.second_byte;
    in_data_byte   <= it.data_byte;
    do @(posedge clk); while (in_stall);
    enc_sb.note_accepted(it);
  endtask

  task automatic send_load(logic [6:0] slot, logic [7:0] a, logic [7:0] b);
    enc_item_t it;
    it             = make_item(FUNC_LOAD);
    it.entry_index = slot;
    it.first_byte  = a;
    it.second_byte = b;
    send_item(it);
  endtask

  task automatic send_data(logic [7:0] d);
    enc_item_t it;
    it           = make_item(FUNC_DATA);
    it.data_byte = d;
    send_item(it);
  endtask

  task automatic send_eos();
    send_item(make_item(FUNC_EOS));
  endtask

  // register writes only once the block has drained and gone quiet
  task automatic idle_and_configure(logic [7:0] count);
    in_valid <= 1'b0;
    while (enc_sb.symbols_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enc_sb.set_dict_entries(count);
    settings_used++;
  endtask

  // output side: random stalls, one long hold to back the block up
  initial begin
    int r;
    int len;
    int hold;
    bit pressure_done;
    pressure_done = 1'b0;
    out_stall     = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!pressure_done && enc_sb.symbols_seen >= 100) begin
        out_stall <= 1'b1;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk);
          hold++;
        end
        pressure_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 30);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 50);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] phase_counts [NUM_PHASES];
    int         p;
    int         i;
    int         r;
    int         len;
    int         sent;
    int         waited;

    enc_sb         = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_NONE;
    in_entry_index = '0;
    in_first_byte  = '0;
    in_second_byte = '0;
    in_data_byte   = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty dictionary: first byte only held, flush, empty flush, ignored func, literals, flush
    idle_and_configure(8'd0);
    send_data(8'h41);
    send_eos();
    send_eos();
    send_item('{FUNC_NONE, 7'h7f, 8'hff, 8'hff, 8'hff});
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h80);
    send_eos();

    // slot 3 duplicates slot 0, so the lower index must win
    send_load(7'd0, 8'h61, 8'h62);
    send_load(7'd1, 8'h62, 8'h63);
    send_load(7'd2, 8'hff, 8'h00);
    send_load(7'd3, 8'h61, 8'h62);
    send_load(7'd127, 8'h00, 8'hff);
    idle_and_configure(8'd4);
    send_data(8'h61);
    send_data(8'h62);
    send_data(8'h62);
    send_data(8'h63);
    send_data(8'hff);
    send_data(8'h00);
    send_data(8'h61);
    send_data(8'h63);
    send_eos();

    // every slot written before any wider search
    for (i = 0; i < DICT_SIZE; i++)
      send_load(i[6:0], pick_byte(15), pick_byte(15));

    phase_counts = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd127,
                     8'($urandom_range(2, 126)), 8'($urandom_range(2, 126)), 8'd129,
                     8'($urandom_range(2, 126)), 8'd128};
    for (p = 0; p < NUM_PHASES; p++) begin
      idle_and_configure(phase_counts[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_load(7'($urandom_range(0, DICT_SIZE - 1)), pick_byte(20), pick_byte(20));
          sent++;
        end else if (r < 13) begin
          send_item(make_item(FUNC_NONE));
        end else if (r < 16) begin
          send_eos();
          sent++;
        end else begin
          // a text run, usually closed by end of stream
          len = $urandom_range(1, 24);
          repeat (len) send_data(pick_byte(15));
          sent += len;
          if ($urandom_range(0, 9) != 0) begin
            send_eos();
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (enc_sb.symbols_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (enc_sb.symbols_due.size() != 0)
      enc_sb.report_mismatch($sformatf("%0d symbols never arrived",
                                       enc_sb.symbols_due.size()));

    $display("run: %0d items accepted under %0d dictionary sizes, %0d mismatches",
             enc_sb.items_seen, settings_used, enc_sb.errors);
    $display("symbols out: %0d total, %0d dictionary codes, %0d end-of-stream flushes",
             enc_sb.symbols_seen, enc_sb.codes_seen, enc_sb.flushes_seen);
    if (enc_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
